>>> sv/sorted_priority_queue_top_defines.svh
// Assertion macros shared by the sorted priority queue checker.
// No dependencies; include by bare file name.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

`endif

>>> sv/spq_pkg.sv
// Package for the sorted priority queue: transaction structs, opcodes, status codes.
// No dependencies.
package spq_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key;
    logic [31:0] ident;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [31:0] out_ident;
    logic [6:0]  occupancy;
  } spq_out_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctl_t;

endpackage

>>> sv/spq_cell.sv
// One slot of the sorted queue chain: holds a key and an identifier.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  spq_ctl_t            ctl,
  input  logic                occ,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [31:0]         new_ident,
  input  logic                prev_stay,
  input  logic [KEY_BITS-1:0] prev_key,
  input  logic [31:0]         prev_ident,
  input  logic [KEY_BITS-1:0] next_key,
  input  logic [31:0]         next_ident,
  output logic                stay,
  output logic [KEY_BITS-1:0] key,
  output logic [31:0]         ident
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [31:0]         ident_r, ident_nxt;

  // Entries at or above the new rank keep their place; equal ranks stay ahead.
  assign stay  = occ && (key_r >= new_key);
  assign key   = key_r;
  assign ident = ident_r;

  always_comb begin
    key_nxt   = key_r;
    ident_nxt = ident_r;
    if (ctl.ins && !stay) begin
      if (prev_stay) begin
        key_nxt   = new_key;
        ident_nxt = new_ident;
      end else begin
        key_nxt   = prev_key;
        ident_nxt = prev_ident;
      end
    end else if (ctl.rem) begin
      key_nxt   = next_key;
      ident_nxt = next_ident;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    ident_r <= ident_nxt;
  end

endmodule

>>> sv/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a chain of spq_cell slots, count and result register.
// Depends on spq_pkg and spq_cell.
//
//   channel | direction | payload   | handshake
//   in_     | input     | spq_in_t  | in_valid / in_stall
//   out_    | output    | spq_out_t | out_valid / out_stall
//
// One transaction per cycle while in_stall is low: every cell compares the new
// rank against its own in parallel and the chain shifts in the same cycle; the
// result is registered and appears in the cycle after acceptance.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result.
// in_stall is high while a result waits and out_stall holds it.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  spq_out_t         out_data_r, out_data_nxt;

  logic                in_acc;
  logic                full, empty;
  logic [31:0]         key_wide;
  logic [KEY_BITS-1:0] k_in;
  spq_ctl_t            ctl;

  logic [KEY_BITS-1:0] key_w   [DEPTH];
  logic [31:0]         ident_w [DEPTH];
  logic                stay_w  [DEPTH];
  logic [31:0]         head_key_wide;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign key_wide = {16'b0, in_data.key};
  assign k_in     = key_wide[KEY_BITS-1:0];

  assign ctl.ins = in_acc && (in_data.kind == KIND_INSERT) && !full;
  assign ctl.rem = in_acc && (in_data.kind == KIND_REMOVE) && !empty;

  // Cell 0 is the head, served next.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                occ;
    logic                p_stay;
    logic [KEY_BITS-1:0] p_key, n_key;
    logic [31:0]         p_ident, n_ident;

    assign occ = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign p_stay  = 1'b1;
      assign p_key   = k_in;
      assign p_ident = in_data.ident;
    end else begin : g_mid
      assign p_stay  = stay_w[i-1];
      assign p_key   = key_w[i-1];
      assign p_ident = ident_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign n_key   = key_w[i];
      assign n_ident = ident_w[i];
    end else begin : g_body
      assign n_key   = key_w[i+1];
      assign n_ident = ident_w[i+1];
    end

    spq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .new_key    (k_in),
      .new_ident  (in_data.ident),
      .prev_stay  (p_stay),
      .prev_key   (p_key),
      .prev_ident (p_ident),
      .next_key   (n_key),
      .next_ident (n_ident),
      .stay       (stay_w[i]),
      .key        (key_w[i]),
      .ident      (ident_w[i])
    );
  end

  assign head_key_wide = 32'(key_w[0]);

  always_comb begin
    count_nxt              = count_r;
    out_data_nxt           = out_data_r;
    out_data_nxt.status    = ST_OK;
    out_data_nxt.out_key   = '0;
    out_data_nxt.out_ident = '0;
    case (in_data.kind)
      KIND_INSERT: begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else begin
          count_nxt              = count_r - CNT_W'(1);
          out_data_nxt.out_key   = head_key_wide[15:0];
          out_data_nxt.out_ident = ident_w[0];
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_data_nxt.occupancy = 7'(count_nxt);
    if (!in_acc) begin
      count_nxt    = count_r;
      out_data_nxt = out_data_r;
    end
  end

  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top_defines.svh.
`include "sorted_priority_queue_top_defines.svh"

module spq_checker import spq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input spq_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input spq_out_t out_data
);

  logic in_acc;
  logic clr_acc;
  logic empty_result;
  logic zero_payload;
  logic clear_result;

  assign in_acc       = in_valid && !in_stall;
  assign clr_acc      = in_acc && (in_data.kind == KIND_CLEAR);
  assign empty_result = out_valid && (out_data.status == ST_EMPTY);
  assign zero_payload = (out_data.out_key == 16'd0) && (out_data.out_ident == 32'd0);
  assign clear_result = (out_data.occupancy == 7'd0) && (out_data.status == ST_OK);

  `SPQ_ASSERT_NEXT(a_result_follows, in_acc, out_valid)
  `SPQ_ASSERT_NEXT(a_clear_empties, clr_acc, clear_result)
  `SPQ_ASSERT_SAME(a_empty_is_zero, empty_result, out_data.occupancy == 7'd0 && zero_payload)
  `SPQ_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
